FILE: sv/apq_pkg.sv
// apq_pkg: shared types and constants of the array priority queue
// opcodes, status codes, controller states and the control/status structs
// used by apq_ctrl, apq_dp and array_priority_queue
package apq_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned FILL_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_INIT,
    S_SHIFT,
    S_SHIFT_END,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_BEST
  } res_sel_e;

  typedef struct packed {
    logic     latch_in;
    logic     enq_wr;
    logic     idx_clr;
    logic     scan_rd;
    logic     shift_init;
    logic     shift_rd;
    logic     cnt_dec;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            cnt_full;
    logic            idx_last;
    logic            shift_none;
  } stat_t;

endpackage

FILE: sv/array_priority_queue.sv
// array_priority_queue: unsorted-array priority queue, one result per item
// enqueue, no-op and an empty dequeue or peek go from EXEC straight to FINISH; a dequeue or
// peek scans the held entries for the best one, and a dequeue then shifts the entries above
// it down one place; FINISH loads the result register once the output register is free
// one item at a time; the next is taken once the result is in the output register
// reset clears the fill count and the handshake state; entry memory is not cleared
module array_priority_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [apq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [apq_pkg::VAL_W-1:0]  item_value_i,
  input  logic [apq_pkg::PRI_W-1:0]         item_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [apq_pkg::ST_W-1:0]          status_o,
  output logic signed [apq_pkg::VAL_W-1:0]  out_value_o,
  output logic [apq_pkg::PRI_W-1:0]         out_priority_o,
  output logic [apq_pkg::FILL_W-1:0]        fill_count_o
);
  import apq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  apq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  apq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .fill_count_o   (fill_count_o)
  );

`ifndef SYNTHESIS
  // an input transfer always starts work, so the next cycle is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |->
      (fill_count_o == '0 && out_value_o == '0 && out_priority_o == '0))
    else $error("empty result carries an entry or a nonzero count");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (out_value_o == '0 && out_priority_o == '0))
    else $error("full result carries an entry");

  // a decrement only happens while entries are held
  a_shift_none_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !stat.cnt_zero)
    else $error("fill count decremented below zero");
`endif

endmodule

FILE: sv/apq_ram.sv
// apq_ram: generic one-write one-read memory with registered read data
// no dependencies
module apq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/apq_ctrl.sv
// apq_ctrl: sequencer of the array priority queue
// depends on apq_pkg; drives apq_dp through cmd_t and reads stat_t
module apq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  apq_pkg::stat_t stat_i,
  output apq_pkg::cmd_t  cmd_o
);
  import apq_pkg::*;

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;
  logic     out_valid_q, out_valid_d;
  logic     slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= RES_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_ENQ: begin
            res_d   = stat_i.cnt_full ? RES_FULL : RES_OK;
            state_d = S_FINISH;
          end
          OP_DEQ, OP_PEEK: begin
            if (stat_i.cnt_zero) begin
              res_d   = RES_EMPTY;
              state_d = S_FINISH;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            res_d   = RES_OK;
            state_d = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.idx_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: begin
        res_d = RES_BEST;
        state_d = (stat_i.op == OP_PEEK) ? S_FINISH : S_SHIFT_INIT;
      end
      S_SHIFT_INIT: begin
        state_d = stat_i.shift_none ? S_FINISH : S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.idx_last) state_d = S_SHIFT_END;
      end
      S_SHIFT_END: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = res_q;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch_in = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.enq_wr  = (stat_i.op == OP_ENQ) && !stat_i.cnt_full;
        cmd_o.idx_clr = (stat_i.op == OP_DEQ || stat_i.op == OP_PEEK) && !stat_i.cnt_zero;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      S_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        cmd_o.cnt_dec    = stat_i.shift_none;
      end
      S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
      end
      S_SHIFT_END: begin
        cmd_o.cnt_dec = 1'b1;
      end
      S_FINISH: begin
        cmd_o.out_load = slot_free;
        if (slot_free) out_valid_d = 1'b1;
      end
      default: begin
        cmd_o.res_sel = res_q;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/apq_dp.sv
// apq_dp: datapath of the array priority queue
// entry memory, fill count, scan/shift index, best-entry tracker, result register
// depends on apq_pkg and apq_ram
module apq_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  apq_pkg::cmd_t                       cmd_i,
  output apq_pkg::stat_t                      stat_o,
  input  logic [apq_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [apq_pkg::VAL_W-1:0]    item_value_i,
  input  logic [apq_pkg::PRI_W-1:0]           item_priority_i,
  output logic [apq_pkg::ST_W-1:0]            status_o,
  output logic signed [apq_pkg::VAL_W-1:0]    out_value_o,
  output logic [apq_pkg::PRI_W-1:0]           out_priority_o,
  output logic [apq_pkg::FILL_W-1:0]          fill_count_o
);
  import apq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = VAL_W + PRI_W;

  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [PRI_W-1:0]        pri_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           idx_q;
  logic [AW-1:0]           data_idx_q;
  logic                    scan_vld_q;
  logic                    shift_vld_q;
  logic signed [VAL_W-1:0] best_val_q;
  logic [PRI_W-1:0]        best_pri_q;
  logic [AW-1:0]           best_idx_q;
  logic [ST_W-1:0]         res_status_q;
  logic signed [VAL_W-1:0] res_value_q;
  logic [PRI_W-1:0]        res_pri_q;
  logic [FILL_W-1:0]       res_fill_q;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [MW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [MW-1:0]           ram_rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic [PRI_W-1:0]        rd_pri;
  logic [CW-1:0]           best_next;
  logic                    take_best;

  assign rd_val    = $signed(ram_rdata[MW-1:PRI_W]);
  assign rd_pri    = ram_rdata[PRI_W-1:0];
  assign best_next = CW'(best_idx_q) + CW'(1);

  // shift writes land one place below the entry just read
  assign ram_we    = cmd_i.enq_wr || shift_vld_q;
  assign ram_waddr = shift_vld_q ? (data_idx_q - AW'(1)) : count_q[AW-1:0];
  assign ram_wdata = shift_vld_q ? ram_rdata : {val_q, pri_q};
  assign ram_re    = cmd_i.scan_rd || cmd_i.shift_rd;

  apq_ram #(
    .WIDTH(MW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // strict compare keeps the earliest arrival among equal priorities
  assign take_best = scan_vld_q && ((data_idx_q == '0) || (rd_pri > best_pri_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      scan_vld_q  <= 1'b0;
      shift_vld_q <= 1'b0;
    end else begin
      scan_vld_q  <= cmd_i.scan_rd;
      shift_vld_q <= cmd_i.shift_rd;
      if (cmd_i.enq_wr) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.shift_init) begin
        idx_q <= best_next;
      end else if (ram_re) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= opcode_i;
      val_q <= item_value_i;
      pri_q <= item_priority_i;
    end
    if (ram_re) begin
      data_idx_q <= idx_q[AW-1:0];
    end
    if (take_best) begin
      best_val_q <= rd_val;
      best_pri_q <= rd_pri;
      best_idx_q <= data_idx_q;
    end
    if (cmd_i.out_load) begin
      res_fill_q <= FILL_W'(count_q);
      unique case (cmd_i.res_sel)
        RES_OK: begin
          res_status_q <= ST_OK;
          res_value_q  <= '0;
          res_pri_q    <= '0;
        end
        RES_FULL: begin
          res_status_q <= ST_FULL;
          res_value_q  <= '0;
          res_pri_q    <= '0;
        end
        RES_EMPTY: begin
          res_status_q <= ST_EMPTY;
          res_value_q  <= '0;
          res_pri_q    <= '0;
        end
        RES_BEST: begin
          res_status_q <= ST_OK;
          res_value_q  <= best_val_q;
          res_pri_q    <= best_pri_q;
        end
        default: begin
          res_status_q <= ST_OK;
          res_value_q  <= '0;
          res_pri_q    <= '0;
        end
      endcase
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.cnt_zero   = (count_q == '0);
  assign stat_o.cnt_full   = (count_q == CW'(CAPACITY));
  assign stat_o.idx_last   = (idx_q == (count_q - CW'(1)));
  assign stat_o.shift_none = (best_next == count_q);

  assign status_o       = res_status_q;
  assign out_value_o    = res_value_q;
  assign out_priority_o = res_pri_q;
  assign fill_count_o   = res_fill_q;

endmodule

FILE: tb/apq_checker.sv
`timescale 1ns / 100ps
// apq_checker: watches both channels of array_priority_queue, keeps its own copy
// of the entry array and compares every result transfer field by field; needs apq_pkg
module apq_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [apq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [apq_pkg::VAL_W-1:0]  item_value_i,
  input  logic [apq_pkg::PRI_W-1:0]         item_priority_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [apq_pkg::ST_W-1:0]          status_i,
  input  logic signed [apq_pkg::VAL_W-1:0]  out_value_i,
  input  logic [apq_pkg::PRI_W-1:0]         out_priority_i,
  input  logic [apq_pkg::FILL_W-1:0]        fill_count_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       results_o,
  output int unsigned                       full_hits_o,
  output int unsigned                       empty_hits_o,
  output int unsigned                       peak_fill_o
);
  import apq_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;
    logic [FILL_W-1:0]       fill;
  } result_t;

  logic signed [VAL_W-1:0] held_values [CAPACITY];
  logic [PRI_W-1:0]        held_prios  [CAPACITY];
  int unsigned             held_count = 0;

  result_t     due_results [$];
  result_t     oldest;
  int unsigned fails      = 0;
  int unsigned owed       = 0;
  int unsigned results    = 0;
  int unsigned full_hits  = 0;
  int unsigned empty_hits = 0;
  int unsigned peak_fill  = 0;

  assign fail_count_o = fails;
  assign pending_o    = owed;
  assign results_o    = results;
  assign full_hits_o  = full_hits;
  assign empty_hits_o = empty_hits;
  assign peak_fill_o  = peak_fill;

  // applies one operation to the local entry array and returns its result
  function automatic result_t apply_queue_op(logic [OP_W-1:0] op,
                                             logic signed [VAL_W-1:0] val,
                                             logic [PRI_W-1:0] prio);
    result_t     res;
    int unsigned best;
    int unsigned k;
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_values[held_count] = val;
          held_prios[held_count]  = prio;
          held_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // strict compare keeps the earliest arrival among equal priorities
          best = 0;
          for (k = 1; k < held_count; k++) begin
            if (held_prios[k] > held_prios[best]) best = k;
          end
          res.value = held_values[best];
          res.prio  = held_prios[best];
          if (op == OP_DEQ) begin
            for (k = best; k + 1 < held_count; k++) begin
              held_values[k] = held_values[k + 1];
              held_prios[k]  = held_prios[k + 1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    res.fill = FILL_W'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t: result %0d %s: got %0h, expected %0h", $time, results, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      due_results.delete();
      owed = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (due_results.size() == 0) begin
          report_mismatch("transfer with nothing owed", status_i, '0);
        end else begin
          oldest = due_results.pop_front();
          if (status_i !== oldest.status) report_mismatch("status", status_i, oldest.status);
          if (out_value_i !== oldest.value) report_mismatch("value", out_value_i, oldest.value);
          if (out_priority_i !== oldest.prio) begin
            report_mismatch("priority", out_priority_i, oldest.prio);
          end
          if (fill_count_i !== oldest.fill) begin
            report_mismatch("fill count", fill_count_i, oldest.fill);
          end
          if (oldest.status == ST_FULL) full_hits++;
          if (oldest.status == ST_EMPTY) empty_hits++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(apply_queue_op(opcode_i, item_value_i, item_priority_i));
        if (held_count > peak_fill) peak_fill = held_count;
      end
      owed = due_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: top of the array_priority_queue testbench, drives directed and phased random
// operations with random idling on both sides; needs apq_pkg, the block and apq_checker
module tb;
  import apq_pkg::*;

  localparam int unsigned CAP          = 128;
  localparam int          CLK_PERIOD   = 8;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOLD_CYCLES  = 500;

  typedef enum {PH_FILL, PH_DRAIN, PH_TIES, PH_MIXED} phase_e;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         opcode        = OP_NOP;
  logic signed [VAL_W-1:0] item_value    = '0;
  logic [PRI_W-1:0]        item_priority = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] out_value;
  logic [PRI_W-1:0]        out_priority;
  logic [FILL_W-1:0]       fill_count;

  int unsigned fail_count, pending, results, full_hits, empty_hits, peak_fill;
  int unsigned sent     = 0;
  bit          no_idle  = 1'b0;
  bit          hold_req = 1'b0;

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  array_priority_queue #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .item_value_i   (item_value),
    .item_priority_i(item_priority),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .out_value_o    (out_value),
    .out_priority_o (out_priority),
    .fill_count_o   (fill_count)
  );

  apq_checker #(
    .CAPACITY(CAP)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .item_value_i   (item_value),
    .item_priority_i(item_priority),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .out_value_i    (out_value),
    .out_priority_i (out_priority),
    .fill_count_i   (fill_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .full_hits_o    (full_hits),
    .empty_hits_o   (empty_hits),
    .peak_fill_o    (peak_fill)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(phase_e ph);
    int unsigned r, enq_lim, deq_lim;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_NOP;
    case (ph)
      PH_FILL: begin
        enq_lim = 83;
        deq_lim = 93;
      end
      PH_DRAIN: begin
        enq_lim = 15;
        deq_lim = 85;
      end
      default: begin
        enq_lim = 45;
        deq_lim = 78;
      end
    endcase
    if (r < enq_lim) return OP_ENQ;
    if (r < deq_lim) return OP_DEQ;
    return OP_PEEK;
  endfunction

  function automatic logic [PRI_W-1:0] pick_prio(phase_e ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    // narrow range gives long runs of equal priorities
    if (ph == PH_TIES) return (r < 20) ? 8'hff : PRI_W'($urandom_range(0, 2));
    if (r < 8) return '0;
    if (r < 16) return 8'hff;
    return PRI_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h7fff_ffff;
    if (r < 10) return 32'h8000_0000;
    if (r < 13) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                      logic [PRI_W-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    item_value    <= val;
    item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned n;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off: a result waits in the output register and the block stalls its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    phase_e      phase;
    int unsigned phase_len;
    int unsigned done;
    int unsigned drain_wait;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, fields of dequeue and peek ignored
    send(OP_PEEK, 32'sd9, 8'd3);
    send(OP_DEQ, '1, 8'hff);
    send(OP_NOP, '1, 8'hff);
    // extremes and a three-way tie at the top priority
    send(OP_ENQ, 32'h7fff_ffff, 8'h00);
    send(OP_ENQ, 32'h8000_0000, 8'hff);
    send(OP_ENQ, 32'h0000_0000, 8'hff);
    send(OP_ENQ, 32'hffff_ffff, 8'h80);
    send(OP_ENQ, 32'h0000_0001, 8'hff);
    send(OP_PEEK, '0, '0);
    send(OP_NOP, '0, '0);
    repeat (5) send(OP_DEQ, '0, '0);
    send(OP_DEQ, '0, '0);
    send(OP_PEEK, '0, '0);
    send(OP_ENQ, 32'h5555_5555, 8'haa);
    send(OP_ENQ, 32'haaaa_aaaa, 8'h55);
    send(OP_PEEK, '0, '0);
    send(OP_DEQ, '0, '0);
    send(OP_DEQ, '0, '0);

    // phases: fill to capacity, drain to empty, tie-heavy, mixed
    done  = 0;
    phase = PH_FILL;
    while (done < RANDOM_ITEMS) begin
      phase_len = (phase == PH_FILL) ? $urandom_range(180, 260) : $urandom_range(100, 240);
      no_idle   = (done != 0) && ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (done == 100) hold_req = 1'b1;
        send(pick_op(phase), pick_value(), pick_prio(phase));
        done++;
        if (done >= RANDOM_ITEMS) break;
      end
      case (phase)
        PH_FILL:  phase = PH_DRAIN;
        PH_DRAIN: phase = PH_TIES;
        PH_TIES:  phase = PH_MIXED;
        default:  phase = PH_FILL;
      endcase
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    drain_wait = 0;
    while (pending != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (300) @(posedge clk);

    if (pending != 0) $display("%0d results never arrived", pending);
    $display("%0d operations, %0d results checked: %0d full rejections, %0d empty reports",
             sent, results, full_hits, empty_hits);
    $display("peak fill %0d of %0d, one output hold-off of %0d cycles",
             peak_fill, CAP, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000 * CLK_PERIOD);
    $display("timeout with %0d results owed", pending);
    $display("tb failed");
    $finish;
  end

endmodule
